// File: hw/rtl/glmf_pkg.sv
// ----------------------------------------------------------------------------
// glmf_pkg: shared definitions for the grid local maximum finder
// Field widths, register map, controller states and the four-neighbor test.
// ----------------------------------------------------------------------------
`default_nettype none

package glmf_pkg;

  // Payload field widths
  localparam int SAMPLE_W   = 16;
  localparam int PEAK_ROW_W = 10;
  localparam int PEAK_COL_W = 5;
  localparam int OUT_DATA_W = 16;

  // Configuration register widths and limits
  localparam int ROWS_CFG_W = 11;
  localparam int COLS_CFG_W = 6;
  localparam int MAX_ROWS   = 1024;
  localparam int MAX_COLS   = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes (word address)
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // Controller states
  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_t;

  // A cell is a peak if it is not below any neighbor that exists
  function automatic logic peak_test(
    input logic signed [SAMPLE_W-1:0] self,
    input logic                       has_up,
    input logic signed [SAMPLE_W-1:0] up,
    input logic                       has_left,
    input logic signed [SAMPLE_W-1:0] left,
    input logic                       has_right,
    input logic signed [SAMPLE_W-1:0] right,
    input logic                       has_down,
    input logic signed [SAMPLE_W-1:0] down
  );
    logic below;
    below = (has_up && (self < up)) || (has_left && (self < left)) ||
            (has_right && (self < right)) || (has_down && (self < down));
    return !below;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/glmf_cell.sv
// ----------------------------------------------------------------------------
// glmf_cell: one column slot of the line store
// Holds one sample of the row above and one of the row two above; shifts
// toward column zero on every transaction or loads at the entry slot.
// ----------------------------------------------------------------------------
`default_nettype none

module glmf_cell (
  input  wire logic                                  clk,
  input  wire logic                                  shift_en,
  input  wire logic                                  entry,
  input  wire logic signed [glmf_pkg::SAMPLE_W-1:0]  rec_ins,
  input  wire logic signed [glmf_pkg::SAMPLE_W-1:0]  old_ins,
  input  wire logic signed [glmf_pkg::SAMPLE_W-1:0]  rec_nbr,
  input  wire logic signed [glmf_pkg::SAMPLE_W-1:0]  old_nbr,
  output logic signed      [glmf_pkg::SAMPLE_W-1:0]  rec_q,
  output logic signed      [glmf_pkg::SAMPLE_W-1:0]  old_q
);

  logic signed [glmf_pkg::SAMPLE_W-1:0] rec_r, rec_nxt;
  logic signed [glmf_pkg::SAMPLE_W-1:0] old_r, old_nxt;

  // Entry slot takes the new values, others take the neighbor's
  always_comb begin
    rec_nxt = entry ? rec_ins : rec_nbr;
    old_nxt = entry ? old_ins : old_nbr;
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    if (shift_en) begin
      rec_r <= rec_nxt;
      old_r <= old_nxt;
    end
  end

  assign rec_q = rec_r;
  assign old_q = old_r;

endmodule

`default_nettype wire

// File: hw/rtl/glmf_line_chain.sv
// ----------------------------------------------------------------------------
// glmf_line_chain: two-row line store built as a chain of cells
// New samples enter at the slot of the last grid column and move one slot
// toward column zero per transaction, so slot zero always holds the cell
// above the incoming sample and slot one the cell above and to the right.
// ----------------------------------------------------------------------------
`default_nettype none

module glmf_line_chain #(
  parameter int MAX_COLS = glmf_pkg::MAX_COLS
) (
  input  wire logic                                  clk,
  input  wire logic                                  shift_en,
  input  wire logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_last,
  input  wire logic signed [glmf_pkg::SAMPLE_W-1:0]  sample,
  output logic signed      [glmf_pkg::SAMPLE_W-1:0]  mid,
  output logic signed      [glmf_pkg::SAMPLE_W-1:0]  up,
  output logic signed      [glmf_pkg::SAMPLE_W-1:0]  right
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic signed [glmf_pkg::SAMPLE_W-1:0] rec_q [MAX_COLS];
  logic signed [glmf_pkg::SAMPLE_W-1:0] old_q [MAX_COLS];

  // Row of cells; the top slot wraps its neighbor input to the sample
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    logic signed [glmf_pkg::SAMPLE_W-1:0] rec_nbr;
    logic signed [glmf_pkg::SAMPLE_W-1:0] old_nbr;

    if (i == MAX_COLS - 1) begin : g_top
      assign rec_nbr = sample;
      assign old_nbr = rec_q[0];
    end else begin : g_mid
      assign rec_nbr = rec_q[i+1];
      assign old_nbr = old_q[i+1];
    end

    glmf_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .entry    (col_last == COL_W'(i)),
      .rec_ins  (sample),
      .old_ins  (rec_q[0]),
      .rec_nbr  (rec_nbr),
      .old_nbr  (old_nbr),
      .rec_q    (rec_q[i]),
      .old_q    (old_q[i])
    );
  end

  // Taps at the head of the chain
  assign mid = rec_q[0];
  assign up  = old_q[0];

  if (MAX_COLS > 1) begin : g_right
    assign right = rec_q[1];
  end else begin : g_no_right
    assign right = '0;
  end

endmodule

`default_nettype wire

// File: hw/rtl/grid_local_maximum_finder_top.sv
// ----------------------------------------------------------------------------
// grid_local_maximum_finder_top: four-neighbor local maximum finder
// A result above the last row is registered in the cycle after the sample
// below it is taken. Throughput: one sample per cycle while the output
// accepts; after a grid's final sample input stalls while last-row flags drain.
// Reset: synchronous; grid set to 1x1, raster position and last-row flags
// cleared; the line store cells are not reset and are filled per grid.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_local_maximum_finder_top #(
  parameter int MAX_COLS = glmf_pkg::MAX_COLS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // APB-style configuration port
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [glmf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [glmf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [glmf_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready,
  // Sample stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [glmf_pkg::SAMPLE_W-1:0]       in_tdata,   // [15:0] sample
  // Peak stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [glmf_pkg::OUT_DATA_W-1:0]     out_tdata,  // [9:0] peak_row,
                                                               // [14:10] peak_col
  output logic                                     out_tlast   // last_of_run
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int VW    = glmf_pkg::SAMPLE_W;
  localparam int RW    = glmf_pkg::PEAK_ROW_W;

  glmf_pkg::state_t state_r, state_nxt;

  logic [glmf_pkg::ROWS_CFG_W-1:0] grid_rows_r;
  logic [glmf_pkg::COLS_CFG_W-1:0] grid_cols_r;

  logic [RW-1:0]          row_r;
  logic [COL_W-1:0]       col_r;
  logic [MAX_COLS-1:0]    flags_r, flags_nxt;
  logic [MAX_COLS-1:0]    flush_vec_r;
  logic [RW-1:0]          flush_row_r;

  logic signed [VW-1:0]   left_hold_r, prev1_r, prev2_r;

  logic                                  out_valid_r;
  logic [RW-1:0]                         out_row_r;
  logic [glmf_pkg::PEAK_COL_W-1:0]       out_col_r;
  logic                                  out_last_r;

  logic                                  cfg_wr;
  logic                                  cfg_idx;
  logic [glmf_pkg::ROWS_CFG_W-1:0]       rows_eff;
  logic [glmf_pkg::COLS_CFG_W-1:0]       cols_eff;
  logic [RW-1:0]                         row_last;
  logic [COL_W-1:0]                      col_last;

  logic                  in_fire, out_space, flush_load;
  logic                  restart, last_row, last_col, last_pix;
  logic [RW-1:0]         r;
  logic [COL_W-1:0]      c;
  logic signed [VW-1:0]  x, mid, up, right;
  logic                  dec, f_left, f_here, any_flag;
  logic [MAX_COLS-1:0]   low_oh, rest;
  logic [COL_W-1:0]      low_idx;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= glmf_pkg::ROWS_CFG_W'(1);
      grid_cols_r <= glmf_pkg::COLS_CFG_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        glmf_pkg::REG_GRID_ROWS: grid_rows_r <= cfg_pwdata[glmf_pkg::ROWS_CFG_W-1:0];
        glmf_pkg::REG_GRID_COLS: grid_cols_r <= cfg_pwdata[glmf_pkg::COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      glmf_pkg::REG_GRID_ROWS: cfg_prdata = glmf_pkg::CFG_DATA_W'(grid_rows_r);
      glmf_pkg::REG_GRID_COLS: cfg_prdata = glmf_pkg::CFG_DATA_W'(grid_cols_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // Out-of-range sizes clamp to the supported range
  always_comb begin
    if (grid_rows_r == '0)
      rows_eff = glmf_pkg::ROWS_CFG_W'(1);
    else if (grid_rows_r > glmf_pkg::ROWS_CFG_W'(glmf_pkg::MAX_ROWS))
      rows_eff = glmf_pkg::ROWS_CFG_W'(glmf_pkg::MAX_ROWS);
    else
      rows_eff = grid_rows_r;

    if (grid_cols_r == '0)
      cols_eff = glmf_pkg::COLS_CFG_W'(1);
    else if (grid_cols_r > glmf_pkg::COLS_CFG_W'(MAX_COLS))
      cols_eff = glmf_pkg::COLS_CFG_W'(MAX_COLS);
    else
      cols_eff = grid_cols_r;

    row_last = RW'(rows_eff - glmf_pkg::ROWS_CFG_W'(1));
    col_last = COL_W'(cols_eff - glmf_pkg::COLS_CFG_W'(1));
  end

  // --------------------------------------------------------------------------
  // Line store
  // --------------------------------------------------------------------------
  assign x = $signed(in_tdata);

  glmf_line_chain #(
    .MAX_COLS (MAX_COLS)
  ) u_chain (
    .clk      (clk),
    .shift_en (in_fire),
    .col_last (col_last),
    .sample   (x),
    .mid      (mid),
    .up       (up),
    .right    (right)
  );

  // --------------------------------------------------------------------------
  // Per-sample decisions
  // --------------------------------------------------------------------------
  assign in_fire   = in_tvalid & in_tready;
  assign out_space = !out_valid_r || out_tready;

  always_comb begin
    restart  = (row_r > row_last) || (col_r > col_last);
    r        = restart ? '0 : row_r;
    c        = restart ? '0 : col_r;
    last_row = (r == row_last);
    last_col = (c == col_last);
    last_pix = last_row && last_col;

    // Cell above the incoming sample
    dec = (r != '0) &&
          glmf_pkg::peak_test(mid, r > RW'(1), up, c != '0, left_hold_r,
                              c < col_last, right, 1'b1, x);

    // Last row: cell to the left now has its right neighbor
    f_left = glmf_pkg::peak_test(prev1_r, r != '0, left_hold_r, c > COL_W'(1),
                                 prev2_r, 1'b1, x, 1'b0, '0);
    // Last cell of the grid has all its neighbors
    f_here = glmf_pkg::peak_test(x, r != '0, mid, c != '0, prev1_r,
                                 1'b0, '0, 1'b0, '0);

    flags_nxt = restart ? '0 : flags_r;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (last_row && (c != '0) && (COL_W'(i) == c - COL_W'(1)))
        flags_nxt[i] = f_left;
      if (last_pix && (COL_W'(i) == c))
        flags_nxt[i] = f_here;
    end
    any_flag = |flags_nxt;
  end

  // Lowest pending last-row flag
  always_comb begin
    low_oh  = flush_vec_r & (~flush_vec_r + MAX_COLS'(1));
    rest    = flush_vec_r & ~low_oh;
    low_idx = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (low_oh[i])
        low_idx = low_idx | COL_W'(i);
    end
  end

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      glmf_pkg::ST_RUN: begin
        if (in_fire && last_pix && any_flag)
          state_nxt = glmf_pkg::ST_FLUSH;
      end
      glmf_pkg::ST_FLUSH: begin
        if (flush_load && (rest == '0))
          state_nxt = glmf_pkg::ST_RUN;
      end
      default: state_nxt = glmf_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    flush_load = 1'b0;
    case (state_r)
      glmf_pkg::ST_RUN:   in_tready  = out_space;
      glmf_pkg::ST_FLUSH: flush_load = out_space;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= glmf_pkg::ST_RUN;
    else
      state_r <= state_nxt;
  end

  // Raster position and last-row flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      flags_r     <= '0;
      flush_vec_r <= '0;
    end else if (cfg_wr) begin
      row_r   <= '0;
      col_r   <= '0;
      flags_r <= '0;
    end else if (in_fire) begin
      if (last_pix) begin
        row_r       <= '0;
        col_r       <= '0;
        flags_r     <= '0;
        flush_vec_r <= flags_nxt;
      end else begin
        flags_r <= flags_nxt;
        if (last_col) begin
          row_r <= r + RW'(1);
          col_r <= '0;
        end else begin
          row_r <= r;
          col_r <= c + COL_W'(1);
        end
      end
    end else if (flush_load) begin
      flush_vec_r <= rest;
    end
  end

  // Neighbor history, payload only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      left_hold_r <= mid;
      prev1_r     <= x;
      prev2_r     <= prev1_r;
      if (last_pix)
        flush_row_r <= r;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (in_fire)
      out_valid_r <= dec;
    else if (flush_load)
      out_valid_r <= 1'b1;
    else if (out_tready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_fire && dec) begin
      out_row_r  <= r - RW'(1);
      out_col_r  <= glmf_pkg::PEAK_COL_W'(c);
      out_last_r <= !(last_pix && any_flag);
    end else if (flush_load) begin
      out_row_r  <= flush_row_r;
      out_col_r  <= glmf_pkg::PEAK_COL_W'(low_idx);
      out_last_r <= (rest == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_flush_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_pix && any_flag) |=> (state_r == glmf_pkg::ST_FLUSH))
    else $error("final sample with last-row peaks did not start the flush");

  a_run_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == glmf_pkg::ST_RUN) |-> (flush_vec_r == '0))
    else $error("last-row flags pending outside the flush");

  a_flush_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == glmf_pkg::ST_FLUSH) |-> (flush_vec_r != '0))
    else $error("flush state with no flag left to send");

  a_flush_tlast: assert property (@(posedge clk) disable iff (!rst_n)
    flush_load |=> (out_tvalid && (out_tlast == (flush_vec_r == '0))))
    else $error("flush transaction marked last at the wrong place");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> ((row_r == '0) && (col_r == '0) && (flags_r == '0)))
    else $error("register write did not restart the grid");

endmodule

`default_nettype wire
